### rtl/core/lfct_pkg.sv
// ----------------------------------------------------------------------------
// lfct_pkg
// Shared types and constants for the LRU frame cache tracker.
// ----------------------------------------------------------------------------
package lfct_pkg;

    // Fixed widths of the frame key and the capacity register
    localparam int FRAME_BITS   = 32;
    localparam int CFG_BITS     = 5;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 32;

    // Capacity after reset
    localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in func
    localparam logic FUNC_LOOKUP  = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // One input word as held in the input register
    typedef struct packed {
        logic                  func;
        logic [FRAME_BITS-1:0] frame_key;
        logic                  load_ok;
    } t_req_word;

endpackage

### rtl/core/lfct_req_if.sv
// ----------------------------------------------------------------------------
// lfct_req_if
// Input channel: one lookup or request word per handshake.
// ----------------------------------------------------------------------------
interface lfct_req_if
    import lfct_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [FRAME_BITS-1:0] frame_key;
    logic                  load_ok;

    modport source (output valid, output func, output frame_key, output load_ok,
                    input ready);
    modport sink   (input valid, input func, input frame_key, input load_ok,
                    output ready);
endinterface

### rtl/core/lfct_rsp_if.sv
// ----------------------------------------------------------------------------
// lfct_rsp_if
// Result channel: one result word per input word.
// ----------------------------------------------------------------------------
interface lfct_rsp_if
    import lfct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) ();
    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [SLOT_BITS-1:0]  slot;
    logic                  ready_res;
    logic                  evicted;
    logic [FRAME_BITS-1:0] evicted_frame;

    modport source (output valid, output found, output slot, output ready_res,
                    output evicted, output evicted_frame, input ready);
    modport sink   (input valid, input found, input slot, input ready_res,
                    input evicted, input evicted_frame, output ready);
endinterface

### rtl/core/lfct_cfg_if.sv
// ----------------------------------------------------------------------------
// lfct_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lfct_cfg_if
    import lfct_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

### rtl/core/lfct_store.sv
// ----------------------------------------------------------------------------
// lfct_store
// Key tags, valid bits, recency ranks and occupancy, with the parallel
// compare and rank update for one word.
// ----------------------------------------------------------------------------
module lfct_store
    import lfct_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_req_word             i_item,
    input  logic [CFG_BITS-1:0]   i_capacity,
    output logic                  o_found,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_slot,
    output logic                  o_ready_res,
    output logic                  o_evicted,
    output logic [FRAME_BITS-1:0] o_evicted_frame
);
    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int KW        = (KEY_BITS < FRAME_BITS) ? KEY_BITS : FRAME_BITS;
    localparam int CMP_BITS  = ((CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS) + 1;

    logic [KW-1:0]        r_key  [ENTRIES];
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [SLOT_BITS-1:0] r_rank [ENTRIES];
    logic [SLOT_BITS-1:0] n_rank [ENTRIES];
    logic [CNT_BITS-1:0]  r_occ, n_occ;

    logic [KW-1:0]        w_key;
    logic [ENTRIES-1:0]   w_match, w_evict, w_keep, w_oldest;
    logic                 w_hit;
    logic [SLOT_BITS-1:0] w_hit_idx, w_hit_rank, w_free_idx, w_old_rank;
    logic                 w_free_ok;
    logic [CMP_BITS-1:0]  w_cap_ext;
    logic [CNT_BITS-1:0]  w_eff_cap, w_lim;
    logic                 w_evict_any;
    logic [KW-1:0]        w_ev_key;
    logic                 w_is_req, w_load, w_touch, w_insert;

    assign w_key = i_item.frame_key[KW-1:0];

    // Compare the key against every resident tag
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == w_key);
            if (w_match[i]) begin
                w_hit_idx = SLOT_BITS'(i);
            end
        end
    end

    assign w_hit      = |w_match;
    assign w_hit_rank = r_rank[w_hit_idx];

    // Clamp capacity to 1..ENTRIES; ranks at or above the limit go out on insert
    assign w_cap_ext = CMP_BITS'(i_capacity);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_eff_cap = CNT_BITS'(1);
        end else if (w_cap_ext >= CMP_BITS'(ENTRIES)) begin
            w_eff_cap = CNT_BITS'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext[CNT_BITS-1:0];
        end
    end
    assign w_lim       = w_eff_cap - CNT_BITS'(1);
    assign w_evict_any = r_occ > w_lim;
    // Ranks are a permutation of 0..occupancy-1, so the oldest has occupancy-1
    assign w_old_rank  = SLOT_BITS'(r_occ - CNT_BITS'(1));

    // Mark victims and pick out the oldest victim's key
    always_comb begin
        w_ev_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_evict[i]  = r_valid[i] && (CNT_BITS'(r_rank[i]) >= w_lim);
            w_oldest[i] = r_valid[i] && (r_rank[i] == w_old_rank);
            if (w_oldest[i]) begin
                w_ev_key = w_ev_key | r_key[i];
            end
        end
    end
    assign w_keep = r_valid & ~w_evict;

    // Find the lowest free slot after eviction
    always_comb begin
        w_free_idx = '0;
        w_free_ok  = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!w_keep[i]) begin
                w_free_idx = SLOT_BITS'(i);
                w_free_ok  = 1'b1;
            end
        end
    end

    assign w_is_req = (i_item.func == FUNC_REQUEST);
    assign w_load   = !w_hit && w_is_req && i_item.load_ok;
    assign w_touch  = w_hit && w_is_req;
    assign w_insert = w_load && w_free_ok;

    // Result word
    assign o_found         = w_hit;
    assign o_slot          = w_hit ? w_hit_idx : (w_insert ? w_free_idx : '0);
    assign o_ready_res     = w_touch || w_insert;
    assign o_evicted       = w_load && w_evict_any;
    assign o_evicted_frame = (w_load && w_evict_any) ? FRAME_BITS'(w_ev_key) : '0;

    // Next valid bits, ranks and occupancy
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        if (w_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                    n_rank[i] = r_rank[i] + SLOT_BITS'(1);
                end
            end
            n_rank[w_hit_idx] = '0;
        end else if (w_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_keep[i]) begin
                    n_rank[i] = r_rank[i] + SLOT_BITS'(1);
                end else if (w_evict[i]) begin
                    n_rank[i] = '0;
                end
            end
            n_rank[w_free_idx]  = '0;
            n_valid             = w_keep;
            n_valid[w_free_idx] = 1'b1;
            n_occ = (w_evict_any ? w_lim : r_occ) + CNT_BITS'(1);
        end
    end

    // Update control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_fire) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_rank  <= n_rank;
        end
    end

    // Write the new tag into the free slot
    always_ff @(posedge i_clk) begin
        if (i_fire && w_insert) begin
            r_key[w_free_idx] <= w_key;
        end
    end

endmodule

### rtl/core/lru_frame_cache_tracker_top.sv
// ----------------------------------------------------------------------------
// lru_frame_cache_tracker_top
// Residency tracker for a fully associative LRU cache of frame keys.
// ----------------------------------------------------------------------------
// Each word passes the input register, then the result register, from input
// handshake to result; the block accepts one word every cycle while the sink
// keeps up, and the throughput is set by the parallel tag compare and rank update
// in lfct_store, which leaves the state ready for the next word at the same
// edge that registers the result. The result register stalls the input side
// only while a finished result is held and the sink is not ready. No clearing
// pass runs after reset; tags are covered by valid bits. Capacity writes are
// taken at any cycle and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module lru_frame_cache_tracker_top
    import lfct_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfct_req_if.sink    i_req,
    lfct_cfg_if.sink    i_cfg,
    lfct_rsp_if.source  o_rsp
);
    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                  r_in_valid;
    t_req_word             r_in;
    logic                  r_out_valid;
    logic                  r_found, r_ready_res, r_evicted;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [FRAME_BITS-1:0] r_evicted_frame;
    logic [CFG_BITS-1:0]   r_capacity;

    logic                  w_advance, w_accept;
    logic                  w_found, w_ready_res, w_evicted;
    logic [SLOT_BITS-1:0]  w_slot;
    logic [FRAME_BITS-1:0] w_evicted_frame;

    // Move a word out of the input register when the result register is free or its word is taken
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_accept    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.capacity;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.func      <= i_req.func;
            r_in.frame_key <= i_req.frame_key;
            r_in.load_ok   <= i_req.load_ok;
        end
    end

    lfct_store #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_advance),
        .i_item          (r_in),
        .i_capacity      (r_capacity),
        .o_found         (w_found),
        .o_slot          (w_slot),
        .o_ready_res     (w_ready_res),
        .o_evicted       (w_evicted),
        .o_evicted_frame (w_evicted_frame)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_found         <= w_found;
            r_slot          <= w_slot;
            r_ready_res     <= w_ready_res;
            r_evicted       <= w_evicted;
            r_evicted_frame <= w_evicted_frame;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found         = r_found;
    assign o_rsp.slot          = r_slot;
    assign o_rsp.ready_res     = r_ready_res;
    assign o_rsp.evicted       = r_evicted;
    assign o_rsp.evicted_frame = r_evicted_frame;

    // An eviction only happens on an insert that completes
    a_evict_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.evicted) |-> o_rsp.ready_res)
        else $error("eviction reported without ready");

    // A new word never lands on a word that has not moved on
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_in_valid) |-> w_advance)
        else $error("input register overwritten");

    // A word that advances always produces a held result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result lost after advance");

endmodule

### test/lru_residency_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_residency_checker
// Watches the request, capacity and result channels of the LRU frame cache
// tracker. It keeps its own copy of the resident keys and their recency order,
// works out the result of every accepted request word, and compares each
// accepted result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lru_residency_checker
    import lfct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfct_req_if         i_req,
    lfct_cfg_if         i_cfg,
    lfct_rsp_if         i_rsp,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    localparam int NUM_SLOTS = ENTRIES_DEF;
    localparam int MAX_SHOWN = 10;
    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic                  found;
        logic [3:0]            slot;
        logic                  ready_res;
        logic                  evicted;
        logic [FRAME_BITS-1:0] evicted_frame;
    } t_residency_result;

    // Shadow copy of the tracker state
    logic [FRAME_BITS-1:0] tag_mem   [NUM_SLOTS];
    logic                  tag_valid [NUM_SLOTS];
    int unsigned           age       [NUM_SLOTS];
    logic [CFG_BITS-1:0]   capacity;

    // Outstanding predictions, oldest at the read pointer
    t_residency_result expected_mem [EXP_DEPTH];
    logic [6:0]        exp_rd   = '0;
    logic [6:0]        exp_wr   = '0;
    int unsigned       failures = 0;

    // Apply one word to the shadow state and return the result it should give
    function automatic t_residency_result predict_residency(logic func,
                                                            logic [FRAME_BITS-1:0] key,
                                                            logic load_ok);
        t_residency_result r;
        int                hit;
        int                free_slot;
        int unsigned       cap;
        int unsigned       hit_age;
        int unsigned       oldest_age;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tag_valid[i] && tag_mem[i] == key)
                hit = i;
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            r.slot  = hit[3:0];
            // Touch: move to most recent, shift the younger ones back by one
            if (func == FUNC_REQUEST) begin
                hit_age = age[hit];
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tag_valid[i] && age[i] < hit_age)
                        age[i]++;
                end
                age[hit]    = 0;
                r.ready_res = 1'b1;
            end
        end else if (func == FUNC_REQUEST && load_ok) begin
            cap = (capacity == 0) ? 1 :
                  (capacity > NUM_SLOTS) ? NUM_SLOTS : int'(capacity);
            oldest_age = 0;
            // Drop every entry that would fall beyond the capacity
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (tag_valid[i] && age[i] + 1 >= cap) begin
                    if (!r.evicted || age[i] > oldest_age) begin
                        oldest_age      = age[i];
                        r.evicted_frame = tag_mem[i];
                    end
                    r.evicted    = 1'b1;
                    tag_valid[i] = 1'b0;
                    age[i]       = 0;
                end
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (tag_valid[i])
                    age[i]++;
            end
            // Insert into the lowest free slot as most recent
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                if (!tag_valid[i])
                    free_slot = i;
            end
            if (free_slot >= 0) begin
                tag_mem[free_slot]   = key;
                tag_valid[free_slot] = 1'b1;
                age[free_slot]       = 0;
                r.slot               = free_slot[3:0];
                r.ready_res          = 1'b1;
            end
        end
        return r;
    endfunction

    // Count a failure, show only the first few
    function automatic void note_failure(string what, t_residency_result want,
                                         t_residency_result seen);
        if (failures < MAX_SHOWN) begin
            $display("%0t %s: expected found=%0d slot=%0d ready=%0d evicted=%0d frame=%h",
                     $time, what, want.found, want.slot, want.ready_res, want.evicted,
                     want.evicted_frame);
            $display("%0t %s: got      found=%0d slot=%0d ready=%0d evicted=%0d frame=%h",
                     $time, what, seen.found, seen.slot, seen.ready_res, seen.evicted,
                     seen.evicted_frame);
        end
        failures++;
    endfunction

    // Track every handshake at the clock edge
    always @(posedge i_clk) begin : watch
        t_residency_result seen;
        t_residency_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tag_mem[i]   = '0;
                tag_valid[i] = 1'b0;
                age[i]       = 0;
            end
            capacity = CAP_RESET;
            exp_rd   = '0;
            exp_wr   = '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                capacity = i_cfg.capacity;
            if (i_rsp.valid && i_rsp.ready) begin
                seen.found         = i_rsp.found;
                seen.slot          = i_rsp.slot;
                seen.ready_res     = i_rsp.ready_res;
                seen.evicted       = i_rsp.evicted;
                seen.evicted_frame = i_rsp.evicted_frame;
                if (exp_wr == exp_rd) begin
                    note_failure("result word with nothing outstanding", '0, seen);
                end else begin
                    want   = expected_mem[exp_rd[5:0]];
                    exp_rd = exp_rd + 7'd1;
                    if (seen !== want)
                        note_failure("result word mismatch", want, seen);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_mem[exp_wr[5:0]] = predict_residency(i_req.func, i_req.frame_key,
                                                              i_req.load_ok);
                exp_wr = exp_wr + 7'd1;
            end
        end
        o_pending    <= 32'(exp_wr - exp_rd);
        o_fail_count <= failures;
    end

endmodule

### test/lru_frame_cache_tracker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_frame_cache_tracker_top_tb
// Drives lookup and request words into the LRU frame cache tracker under a
// series of capacity settings, with random gaps on the sending side and
// random back-pressure on the result side. A directed opening covers misses,
// failed loads, touches, evictions, zero capacity and a lowered capacity;
// random phases then work keys from a small pool so that hits and evictions
// stay frequent. The checker beside the block reports failures.
// ----------------------------------------------------------------------------
module lru_frame_cache_tracker_top_tb;
    import lfct_pkg::*;

    localparam int          RANDOM_PHASES = 11;
    localparam int          PHASE_WORDS   = 100;
    localparam int          POOL_SIZE     = 32;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    bit          send_quiet;
    bit          sink_quiet;

    logic [FRAME_BITS-1:0] key_pool [POOL_SIZE];

    lfct_req_if                          req_ch ();
    lfct_cfg_if                          cfg_ch ();
    lfct_rsp_if #(.ENTRIES(ENTRIES_DEF)) rsp_ch ();

    lru_frame_cache_tracker_top #(
        .ENTRIES  (ENTRIES_DEF),
        .KEY_BITS (KEY_BITS_DEF)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    lru_residency_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_cfg        (cfg_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each word unless the sink is quiet
    initial begin : result_sink
        int unsigned hold;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            hold = sink_quiet ? 0 : $urandom_range(0, 7);
            repeat (hold) begin
                rsp_ch.ready <= 1'b0;
                @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready))
                @(posedge clk);
        end
    end

    // Send one word after a random gap unless sending is quiet, hold until accepted
    task automatic send_word(input logic func, input logic [FRAME_BITS-1:0] key,
                             input logic load_ok);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= func;
        req_ch.frame_key <= key;
        req_ch.load_ok   <= load_ok;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic write_capacity(input logic [CFG_BITS-1:0] cap);
        drain_results();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [CFG_BITS-1:0]   phase_cap [RANDOM_PHASES];
        logic [FRAME_BITS-1:0] key;
        logic                  func;
        int unsigned           eff_cap;
        int unsigned           window;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FUNC_LOOKUP;
        req_ch.frame_key <= '0;
        req_ch.load_ok   <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.capacity  <= '0;
        send_quiet = 1'b0;
        sink_quiet = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        phase_cap = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd5, 5'd17, 5'd2, 5'd8,
                      5'd15, 5'd3, 5'd16};
        phase_cap[8] = 5'($urandom_range(0, 31));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two entries: misses, failed load, inserts, touch, one eviction
        write_capacity(5'd2);
        send_word(FUNC_LOOKUP,  32'h0000_0000, 1'b0);
        send_word(FUNC_LOOKUP,  32'hFFFF_FFFF, 1'b1);
        send_word(FUNC_REQUEST, 32'h0000_0000, 1'b0);
        send_word(FUNC_REQUEST, 32'h0000_0000, 1'b1);
        send_word(FUNC_REQUEST, 32'hFFFF_FFFF, 1'b1);
        send_word(FUNC_LOOKUP,  32'hFFFF_FFFF, 1'b0);
        send_word(FUNC_REQUEST, 32'h0000_0000, 1'b1);
        send_word(FUNC_REQUEST, 32'hAAAA_AAAA, 1'b1);
        send_word(FUNC_LOOKUP,  32'hFFFF_FFFF, 1'b1);
        send_word(FUNC_REQUEST, 32'h0000_0000, 1'b0);

        // Zero capacity acts as one: the insert flushes both entries
        write_capacity(5'd0);
        send_word(FUNC_REQUEST, 32'h5555_5555, 1'b1);
        send_word(FUNC_REQUEST, 32'h1234_5678, 1'b1);

        // Fill three, then lower to one: hit keeps all, next insert drops all
        write_capacity(5'd3);
        send_word(FUNC_REQUEST, 32'h0000_0001, 1'b1);
        send_word(FUNC_REQUEST, 32'h8000_0000, 1'b1);
        write_capacity(5'd1);
        send_word(FUNC_REQUEST, 32'h1234_5678, 1'b1);
        send_word(FUNC_LOOKUP,  32'h0000_0001, 1'b0);
        send_word(FUNC_REQUEST, 32'h7FFF_FFFF, 1'b1);

        // Random phases, state carried across capacity changes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_capacity(phase_cap[p]);
            send_quiet = (p % 4 == 1) || (p % 4 == 3 && p > 4);
            sink_quiet = (p % 4 == 2) || (p % 4 == 3 && p > 4);
            eff_cap = (phase_cap[p] == 0) ? 1 :
                      (phase_cap[p] > ENTRIES_DEF) ? ENTRIES_DEF : int'(phase_cap[p]);
            window = eff_cap + $urandom_range(1, 8);
            if (window > POOL_SIZE)
                window = POOL_SIZE;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Mostly pool keys so that hits stay common
                if ($urandom_range(0, 9) == 0)
                    key = $urandom();
                else
                    key = key_pool[$urandom_range(0, window - 1)];
                func = ($urandom_range(0, 9) < 6) ? FUNC_REQUEST : FUNC_LOOKUP;
                send_word(func, key, $urandom_range(0, 9) < 8);
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
        end
        send_quiet = 1'b0;
        sink_quiet = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
